/* rtl/cwbts_pkg.sv */
// Shared types and constants for the clock with one-button time set.
package cwbts_pkg;

  // Set-time machine states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_START  = 5'b00010,
    ST_HOUR   = 5'b00100,
    ST_MINUTE = 5'b01000,
    ST_END    = 5'b10000
  } mode_t;

  // Externally visible state codes
  localparam logic [2:0] CODE_IDLE   = 3'd0;
  localparam logic [2:0] CODE_START  = 3'd1;
  localparam logic [2:0] CODE_HOUR   = 3'd2;
  localparam logic [2:0] CODE_MINUTE = 3'd3;
  localparam logic [2:0] CODE_END    = 3'd4;

  // Separator marker codes (':', 's', 'h', 'm', 'e')
  localparam logic [2:0] MARK_COLON  = 3'd0;
  localparam logic [2:0] MARK_S      = 3'd1;
  localparam logic [2:0] MARK_H      = 3'd2;
  localparam logic [2:0] MARK_M      = 3'd3;
  localparam logic [2:0] MARK_E      = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] REG_LONG_WAIT  = 2'd0;
  localparam logic [1:0] REG_SHORT_WAIT = 2'd1;

  localparam logic [11:0] LONG_WAIT_RST  = 12'd1700;
  localparam logic [11:0] SHORT_WAIT_RST = 12'd1000;
  localparam logic [11:0] WAIT_MAX       = 12'hFFF;

  localparam logic [4:0] HOUR_LAST = 5'd23;
  localparam logic [5:0] MIN_LAST  = 6'd59;
  localparam logic [5:0] SEC_LAST  = 6'd59;

  // Map a state to its external code
  function automatic logic [2:0] mode_code(mode_t m);
    logic [2:0] c;
    unique case (m)
      ST_IDLE:   c = CODE_IDLE;
      ST_START:  c = CODE_START;
      ST_HOUR:   c = CODE_HOUR;
      ST_MINUTE: c = CODE_MINUTE;
      ST_END:    c = CODE_END;
      default:   c = CODE_IDLE;
    endcase
    return c;
  endfunction

  // Map a state to its separator marker
  function automatic logic [2:0] mode_marker(mode_t m);
    logic [2:0] c;
    unique case (m)
      ST_IDLE:   c = MARK_COLON;
      ST_START:  c = MARK_S;
      ST_HOUR:   c = MARK_H;
      ST_MINUTE: c = MARK_M;
      ST_END:    c = MARK_E;
      default:   c = MARK_COLON;
    endcase
    return c;
  endfunction

endpackage

/* rtl/clock_with_button_time_set_core.sv */
// Time-of-day counter with a one-button set-time state machine.
// A request's result is registered and shows on out_ in the cycle after acceptance.
// One request per cycle unless out_tready stalls; each update is one counter pass.
// in_tready stays high while the result register is empty or being drained.
// Reset (rst_n low, synchronous): time zero, machine idle and disarmed,
// wait registers at 1700 and 1000, no result pending.
module clock_with_button_time_set_core
  import cwbts_pkg::*;
#(
  parameter int TICKS_PER_SECOND = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  // Request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] button_pressed, [7:1] zero
  input  logic        in_tuser,   // [0] cmd: 0 time tick, 1 button sample
  // Result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  // [3:0] tenths, [9:4] seconds, [15:10] minutes, [20:16] hours,
  // [23:21] set_state, [24] time_display_event, [25] blink_on_event,
  // [26] blink_off_event, [27] marker_update, [30:28] marker_code, [31] zero
  output logic [31:0] out_tdata,
  // Configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  localparam int TW = (TICKS_PER_SECOND > 2) ? $clog2(TICKS_PER_SECOND) : 1;
  localparam logic [TW:0] TICK_WRAP = (TW+1)'(TICKS_PER_SECOND);
  localparam logic [TW:0] TICK_HALF = (TW+1)'(TICKS_PER_SECOND / 2);

  logic [11:0]   long_wait_r, short_wait_r;
  logic [TW-1:0] tick_r, tick_nxt;
  logic [5:0]    sec_r, sec_nxt;
  logic [5:0]    min_r, min_nxt;
  logic [4:0]    hour_r, hour_nxt;
  mode_t         mode_r, mode_nxt;
  logic          armed_r, armed_nxt;
  logic [11:0]   wait_r, wait_nxt;
  logic          last_btn_r, last_btn_nxt;

  logic          out_valid_r;
  logic [31:0]   out_data_r, out_data_nxt;

  logic          accept;
  logic          pressed, rise;
  logic [TW:0]   tick_inc;
  logic [11:0]   wait_inc;
  logic          disp, blink_on, blink_off, marker;
  logic [TW+3:0] tick_ext;

  assign cfg_ready  = 1'b1;
  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign pressed  = in_tdata[0];
  assign rise     = pressed && !last_btn_r;
  assign tick_inc = {1'b0, tick_r} + (TW+1)'(1);
  assign wait_inc = (wait_r <= long_wait_r && wait_r != WAIT_MAX) ? wait_r + 12'd1 : wait_r;

  // Compute next time and machine state for the current request
  always_comb begin
    tick_nxt     = tick_r;
    sec_nxt      = sec_r;
    min_nxt      = min_r;
    hour_nxt     = hour_r;
    mode_nxt     = mode_r;
    armed_nxt    = armed_r;
    wait_nxt     = wait_r;
    last_btn_nxt = last_btn_r;
    disp         = 1'b0;
    blink_on     = 1'b0;
    blink_off    = 1'b0;
    marker       = 1'b0;
    if (!in_tuser) begin
      // Time tick: cascade tenths into seconds, minutes, hours
      if (tick_inc == TICK_WRAP) begin
        tick_nxt = '0;
        blink_on = 1'b1;
        if (sec_r == SEC_LAST) begin
          sec_nxt = '0;
          disp    = 1'b1;
          if (min_r == MIN_LAST) begin
            min_nxt  = '0;
            hour_nxt = (hour_r >= HOUR_LAST) ? 5'd0 : hour_r + 5'd1;
          end else begin
            min_nxt = min_r + 6'd1;
          end
        end else begin
          sec_nxt = sec_r + 6'd1;
        end
      end else begin
        tick_nxt = tick_inc[TW-1:0];
        if (tick_inc == TICK_HALF) begin
          blink_off = 1'b1;
        end
      end
    end else begin
      // Button sample: advance the set-time machine
      wait_nxt     = wait_inc;
      last_btn_nxt = pressed;
      unique case (mode_r)
        ST_IDLE: begin
          if (!armed_r) begin
            if (pressed) begin
              armed_nxt = 1'b1;
              wait_nxt  = '0;
            end
          end else if (!pressed) begin
            armed_nxt = 1'b0;
          end else if (wait_inc > long_wait_r) begin
            mode_nxt = ST_START;
            wait_nxt = '0;
            marker   = 1'b1;
          end
        end
        ST_START: begin
          if (rise) begin
            mode_nxt = ST_HOUR;
            wait_nxt = '0;
            marker   = 1'b1;
          end else if (wait_inc > short_wait_r) begin
            mode_nxt = ST_END;
            wait_nxt = '0;
            marker   = 1'b1;
          end
        end
        ST_HOUR: begin
          if (rise) begin
            wait_nxt = '0;
            hour_nxt = (hour_r >= HOUR_LAST) ? 5'd0 : hour_r + 5'd1;
            disp     = 1'b1;
          end else if (wait_inc > short_wait_r) begin
            mode_nxt = ST_MINUTE;
            wait_nxt = '0;
            marker   = 1'b1;
          end
        end
        ST_MINUTE: begin
          if (rise) begin
            wait_nxt = '0;
            sec_nxt  = '0;
            min_nxt  = (min_r >= MIN_LAST) ? 6'd0 : min_r + 6'd1;
            disp     = 1'b1;
          end else if (wait_inc > short_wait_r) begin
            mode_nxt = ST_END;
            wait_nxt = '0;
            marker   = 1'b1;
          end
        end
        ST_END: begin
          if (rise) begin
            mode_nxt = ST_START;
            wait_nxt = '0;
            marker   = 1'b1;
          end else if (wait_inc > long_wait_r) begin
            mode_nxt  = ST_IDLE;
            wait_nxt  = '0;
            armed_nxt = 1'b0;
            marker    = 1'b1;
          end
        end
        default: begin
          mode_nxt  = ST_IDLE;
          armed_nxt = 1'b0;
        end
      endcase
    end
  end

  // Pack the result word
  assign tick_ext = {4'b0, tick_nxt};
  always_comb begin
    out_data_nxt = {1'b0, mode_marker(mode_nxt), marker, blink_off, blink_on, disp,
                    mode_code(mode_nxt), hour_nxt, min_nxt, sec_nxt, tick_ext[3:0]};
  end

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_wait_r  <= LONG_WAIT_RST;
      short_wait_r <= SHORT_WAIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_LONG_WAIT) begin
        long_wait_r <= cfg_data;
      end else if (cfg_index == REG_SHORT_WAIT) begin
        short_wait_r <= cfg_data;
      end
    end
  end

  // Advance state on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r     <= '0;
      sec_r      <= '0;
      min_r      <= '0;
      hour_r     <= '0;
      mode_r     <= ST_IDLE;
      armed_r    <= 1'b0;
      wait_r     <= '0;
      last_btn_r <= 1'b0;
    end else if (accept) begin
      tick_r     <= tick_nxt;
      sec_r      <= sec_nxt;
      min_r      <= min_nxt;
      hour_r     <= hour_nxt;
      mode_r     <= mode_nxt;
      armed_r    <= armed_nxt;
      wait_r     <= wait_nxt;
      last_btn_r <= last_btn_nxt;
    end
  end

  // Result register: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule
